/* sv/sps_pkg.sv */
`default_nettype none

package sps_pkg;

    // Fixed sizes
    localparam int NUM_MOTORS  = 6;
    localparam int TABLE_DEPTH = 8;
    localparam int MOT_W       = 3;
    localparam int PH_W        = 3;
    localparam int POS_W       = 16;
    localparam int STEP_W      = 16;
    localparam int PER_W       = 16;
    localparam int WD_W        = 8;
    localparam int COIL_W      = 4 * NUM_MOTORS;
    localparam int CFG_IDX_W   = 2;

    // Stream payload widths (bits, zero padded)
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 80;

    // Special motors
    localparam logic [MOT_W-1:0] MOTOR_DRIVER  = 3'd2;
    localparam logic [MOT_W-1:0] MOTOR_COUPLED = 3'd5;
    localparam logic [MOT_W-1:0] MOTOR_INVERT  = 3'd3;

    // Register reset values
    localparam logic [PER_W-1:0] START_PERIOD_RST = 16'd15000;
    localparam logic [PER_W-1:0] MIN_PERIOD_RST   = 16'd8000;
    localparam logic [PER_W-1:0] RAMP_DEC_RST     = 16'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DEC     = 2'd2;

    localparam logic [PH_W-1:0] PH_LAST = PH_W'(TABLE_DEPTH - 1);

    // Half-step coil patterns, low nibble drives the coils
    localparam logic [7:0] COIL_TABLE [TABLE_DEPTH] = '{
        8'h88, 8'hAA, 8'h22, 8'h66, 8'h44, 8'h55, 8'h11, 8'h99
    };

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_MOVE_STEPS = 3'd1,
        ACT_MOVE_OFS   = 3'd2,
        ACT_STOP       = 3'd3,
        ACT_HOME       = 3'd4,
        ACT_WD_REFRESH = 3'd5,
        ACT_RAMP_RST   = 3'd6
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic [MOT_W-1:0]         motor;
        logic [STEP_W-1:0]        step_count;
        logic                     move_dir;
        logic signed [POS_W-1:0]  offset;
        logic                     halt_in;
        logic [WD_W-1:0]          watchdog_reload;
    } t_item;

    typedef struct packed {
        logic [COIL_W-1:0]        coils;
        logic [PER_W-1:0]         period;
        logic                     all_idle;
        logic signed [POS_W-1:0]  motor_position;
        logic [STEP_W-1:0]        motor_steps_left;
        logic                     watchdog_expired;
    } t_result;

    typedef struct packed {
        logic [PER_W-1:0] start_period;
        logic [PER_W-1:0] min_period;
        logic [PER_W-1:0] ramp_decrement;
    } t_cfg;

    // Next half-step phase, wrapping within the table
    function automatic logic [PH_W-1:0] step_phase(input logic [PH_W-1:0] p,
                                                    input logic fwd);
        logic [PH_W-1:0] r;
        if (fwd) begin
            r = (p >= PH_LAST) ? '0 : p + PH_W'(1);
        end else begin
            r = (p == '0 || p > PH_LAST) ? PH_LAST : p - PH_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/sps_cfg.sv */
`default_nettype none

module sps_cfg
    import sps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [PER_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register write decode; unused index is ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_PERIOD: n_cfg.start_period   = i_cfg_data;
                CFG_MIN_PERIOD:   n_cfg.min_period     = i_cfg_data;
                CFG_RAMP_DEC:     n_cfg.ramp_decrement = i_cfg_data;
                default:          n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_period   <= START_PERIOD_RST;
            r_cfg.min_period     <= MIN_PERIOD_RST;
            r_cfg.ramp_decrement <= RAMP_DEC_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/sps_engine.sv */
`default_nettype none

module sps_engine
    import sps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    // Motor and sequencer state
    logic [STEP_W-1:0] r_steps [NUM_MOTORS];
    logic [POS_W-1:0]  r_pos   [NUM_MOTORS];
    logic [PH_W-1:0]   r_phase [NUM_MOTORS];
    logic              r_dir   [NUM_MOTORS];
    logic [PER_W-1:0]  r_period;
    logic [WD_W-1:0]   r_wd;
    logic [COIL_W-1:0] r_coil;

    logic [STEP_W-1:0] n_steps [NUM_MOTORS];
    logic [POS_W-1:0]  n_pos   [NUM_MOTORS];
    logic [PH_W-1:0]   n_phase [NUM_MOTORS];
    logic              n_dir   [NUM_MOTORS];
    logic [PER_W-1:0]  n_period;
    logic [WD_W-1:0]   n_wd;
    logic [COIL_W-1:0] n_coil;
    logic              n_expired;

    logic             sel_ok;
    logic [MOT_W-1:0] sel;

    assign sel_ok = (i_item.motor < MOT_W'(NUM_MOTORS));
    assign sel    = sel_ok ? i_item.motor : '0;

    // Item update
    always_comb begin
        logic [COIL_W-1:0] coils;
        logic              mv;
        logic              fwd;
        logic              coupled;
        logic              dec;
        logic              inv;
        logic [POS_W:0]    sum;
        logic [POS_W:0]    mag;
        logic              neg;

        n_steps   = r_steps;
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_dir     = r_dir;
        n_period  = r_period;
        n_wd      = r_wd;
        n_coil    = r_coil;
        n_expired = 1'b0;
        coils     = '0;
        mv        = 1'b0;
        fwd       = 1'b0;
        coupled   = 1'b0;
        dec       = 1'b0;
        sum       = '0;
        mag       = '0;
        neg       = 1'b0;
        inv       = (sel == MOTOR_INVERT);

        case (i_item.action)
            ACT_TICK: begin
                // speed ramp
                if (r_period > i_cfg.min_period) begin
                    n_period = (r_period > i_cfg.ramp_decrement)
                             ? r_period - i_cfg.ramp_decrement : '0;
                end
                if (r_wd == '0) begin
                    // watchdog ran out: drop all motion, keep coils
                    for (int i = 0; i < NUM_MOTORS; i++) begin
                        n_steps[i] = '0;
                    end
                    n_expired = 1'b1;
                end else begin
                    n_wd = r_wd - WD_W'(1);
                    if (!i_item.halt_in) begin
                        for (int i = 0; i < NUM_MOTORS; i++) begin
                            // motor 5 is dragged by motor 2 when idle
                            coupled = (MOT_W'(i) == MOTOR_COUPLED)
                                   && (r_steps[i] == '0)
                                   && (r_steps[MOTOR_DRIVER] != '0);
                            mv  = (r_steps[i] != '0) || coupled;
                            fwd = coupled ? ~r_dir[MOTOR_DRIVER] : r_dir[i];
                            dec = fwd ^ (MOT_W'(i) == MOTOR_INVERT);
                            if (mv) begin
                                coils[4*i +: 4] = COIL_TABLE[r_phase[i]][3:0];
                                n_phase[i]      = step_phase(r_phase[i], fwd);
                                n_dir[i]        = fwd;
                                if (coupled) begin
                                    // pre-move and step cancel out
                                    n_steps[i] = '0;
                                end else begin
                                    n_steps[i] = r_steps[i] - STEP_W'(1);
                                    n_pos[i]   = dec ? r_pos[i] - POS_W'(1)
                                                     : r_pos[i] + POS_W'(1);
                                end
                            end
                        end
                    end
                    n_coil = coils;
                end
            end
            ACT_MOVE_STEPS: begin
                if (sel_ok) begin
                    n_steps[sel] = i_item.step_count;
                    n_dir[sel]   = i_item.move_dir ^ inv;
                end
            end
            ACT_MOVE_OFS: begin
                if (sel_ok) begin
                    sum = {r_pos[sel][POS_W-1], r_pos[sel]}
                        + {i_item.offset[POS_W-1], i_item.offset};
                    neg = sum[POS_W];
                    mag = neg ? (POS_W+1)'(0) - sum : sum;
                    n_steps[sel] = mag[POS_W] ? '1 : mag[STEP_W-1:0];
                    n_dir[sel]   = ~neg ^ inv;
                end
            end
            ACT_STOP: begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    n_steps[i] = '0;
                end
            end
            ACT_HOME: begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    n_steps[i] = '0;
                    n_pos[i]   = '0;
                end
            end
            ACT_WD_REFRESH: begin
                n_wd = i_item.watchdog_reload;
            end
            ACT_RAMP_RST: begin
                n_period = i_cfg.start_period;
            end
            default: begin
                n_wd = r_wd;
            end
        endcase
    end

    // Status after the update
    always_comb begin
        logic idle;
        idle = 1'b1;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            if (n_steps[i] != '0) begin
                idle = 1'b0;
            end
        end
        o_result.coils            = n_coil;
        o_result.period           = n_period;
        o_result.all_idle         = idle;
        o_result.motor_position   = sel_ok ? n_pos[sel] : '0;
        o_result.motor_steps_left = sel_ok ? n_steps[sel] : '0;
        o_result.watchdog_expired = n_expired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_steps[i] <= '0;
                r_pos[i]   <= '0;
                r_phase[i] <= '0;
                r_dir[i]   <= 1'b0;
            end
            r_period <= START_PERIOD_RST;
            r_wd     <= '0;
            r_coil   <= '0;
        end else if (i_fire) begin
            r_steps  <= n_steps;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_dir    <= n_dir;
            r_period <= n_period;
            r_wd     <= n_wd;
            r_coil   <= n_coil;
        end
    end

endmodule

`default_nettype wire

/* sv/six_axis_stepper_phase_sequencer.sv */
// Path: an accepted item sits in the input register, then its result loads into the
// result register once that register is free or draining.
// Throughput: one item per cycle while the output side accepts; the input register frees
// as the result register loads, and the result register holds while the output side stalls.
// Reset (i_rst_n low at a clock edge, synchronous): steps, positions, phases, directions,
// watchdog and coils clear, period returns to 15000, registers take their defaults.
`default_nettype none

module six_axis_stepper_phase_sequencer
    import sps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [PER_W-1:0]     i_cfg_data,
    // Item input
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // step_count[15:0], move_dir[16], offset[32:17], halt_in[33],
    // watchdog_reload[41:34], zero[47:42]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // action[2:0], motor[5:3]
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    // Result output
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // coils[23:0], period[39:24], all_idle[40], motor_position[56:41],
    // motor_steps_left[72:57], watchdog_expired[73], zero[79:74]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    t_cfg    cfg;
    t_item   r_item;
    t_item   in_item;
    t_result eng_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    s_xfer;
    logic    fire;

    sps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sps_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (eng_result)
    );

    // Unpack input transfer
    always_comb begin
        in_item.action          = t_action'(s_axis_tuser[2:0]);
        in_item.motor           = s_axis_tuser[5:3];
        in_item.step_count      = s_axis_tdata[15:0];
        in_item.move_dir        = s_axis_tdata[16];
        in_item.offset          = s_axis_tdata[32:17];
        in_item.halt_in         = s_axis_tdata[33];
        in_item.watchdog_reload = s_axis_tdata[41:34];
    end

    // Handshake: item moves to the result register when that is free or draining
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_item <= in_item;
        end
        if (fire) begin
            r_result <= eng_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_result.watchdog_expired,
                            r_result.motor_steps_left,
                            r_result.motor_position,
                            r_result.all_idle,
                            r_result.period,
                            r_result.coils};

    // Idle report agrees with the addressed motor
    a_idle_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.all_idle |-> r_result.motor_steps_left == '0)
        else $error("all_idle set with steps left on addressed motor");

    // Watchdog expiry always clears every motor
    a_expired_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.watchdog_expired |-> r_result.all_idle)
        else $error("watchdog expiry left a motor moving");

    // Input stalls only when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

/* sim/tb_six_axis_stepper_phase_sequencer.sv */
`default_nettype none

module tb_six_axis_stepper_phase_sequencer;
    import sps_pkg::*;

    // Codes the package does not name
    localparam logic [2:0]           ACT_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int LIMIT        = 2000;  // cycles without any transfer
    localparam int LONG_HOLD    = 300;   // one long output back-pressure stretch
    localparam int LONG_HOLD_AT = 450;   // results seen before it starts
    localparam int MAX_PRINTS   = 40;

    // Half-step coil nibbles, phase 0 first
    localparam logic [3:0] HALF_STEP [TABLE_DEPTH] = '{
        4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9
    };

    typedef struct {
        logic [2:0]        action;
        logic [MOT_W-1:0]  motor;
        logic [STEP_W-1:0] step_count;
        logic              move_dir;
        logic [POS_W-1:0]  offset;
        logic              halt_in;
        logic [WD_W-1:0]   wd_reload;
    } t_cmd;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [PER_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    six_axis_stepper_phase_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Sequencer state as the testbench sees it
    logic [STEP_W-1:0] m_steps [NUM_MOTORS];
    logic [POS_W-1:0]  m_pos   [NUM_MOTORS];
    logic [PH_W-1:0]   m_phase [NUM_MOTORS];
    logic              m_dir   [NUM_MOTORS];
    logic [PER_W-1:0]  m_period;
    logic [WD_W-1:0]   m_wd;
    logic [COIL_W-1:0] m_coils;
    logic [PER_W-1:0]  cfg_start, cfg_min, cfg_dec;

    t_cmd    pending [$];
    t_result status_q [$];
    t_cmd    cur_cmd;
    bit      in_took = 1'b0;
    bit      no_idle = 1'b0;
    bit      long_hold_done = 1'b0;
    int      gap_left = 0, stall_left = 0, hold_left = 0, quiet = 0;
    int      queued_cnt = 0, accepted_cnt = 0, rcv_count = 0, n_errors = 0;
    int      n_ticks = 0, n_halted = 0, n_expired = 0, n_coupled = 0, n_sat = 0;
    int      n_bad_motor = 0;

    // One status per command, after the command's update
    function automatic t_result seq_update(t_cmd c);
        t_result           r;
        logic              m_ok;
        logic              all_zero;
        logic [COIL_W-1:0] lit;
        logic              d;
        int                s;
        r = '0;
        m_ok = (c.motor < NUM_MOTORS);
        if (!m_ok) n_bad_motor++;
        case (c.action)
            ACT_TICK: begin
                n_ticks++;
                if (m_period > cfg_min) m_period = (m_period > cfg_dec) ? m_period - cfg_dec : '0;
                if (m_wd == '0) begin
                    // expired watchdog: drop all steps, coils and phases stay
                    for (int i = 0; i < NUM_MOTORS; i++) m_steps[i] = '0;
                    r.watchdog_expired = 1'b1;
                    n_expired++;
                end else begin
                    m_wd = m_wd - 1'b1;
                    lit = '0;
                    if (c.halt_in) begin
                        n_halted++;
                    end else begin
                        for (int i = 0; i < NUM_MOTORS; i++) begin
                            if (m_steps[i] != '0) begin
                                lit[4*i +: 4] = HALF_STEP[m_phase[i]];
                                // motor 2 drags an idle motor 5 one step the other way
                                if (i == MOTOR_DRIVER && m_steps[MOTOR_COUPLED] == '0) begin
                                    m_steps[MOTOR_COUPLED] = 16'd1;
                                    m_dir[MOTOR_COUPLED] = ~m_dir[MOTOR_DRIVER];
                                    m_pos[MOTOR_COUPLED] = m_dir[MOTOR_COUPLED] ?
                                        m_pos[MOTOR_COUPLED] + 1'b1 : m_pos[MOTOR_COUPLED] - 1'b1;
                                    n_coupled++;
                                end
                                if (m_dir[i]) begin
                                    m_phase[i] = (m_phase[i] >= PH_LAST) ? '0 : m_phase[i] + 1'b1;
                                    m_pos[i] = (i == MOTOR_INVERT) ? m_pos[i] + 1'b1 : m_pos[i] - 1'b1;
                                end else begin
                                    m_phase[i] = (m_phase[i] == '0) ? PH_LAST : m_phase[i] - 1'b1;
                                    m_pos[i] = (i == MOTOR_INVERT) ? m_pos[i] - 1'b1 : m_pos[i] + 1'b1;
                                end
                                m_steps[i] = m_steps[i] - 1'b1;
                            end
                        end
                    end
                    m_coils = lit;
                end
            end
            ACT_MOVE_STEPS: begin
                if (m_ok) begin
                    m_steps[c.motor] = c.step_count;
                    m_dir[c.motor] = (c.motor == MOTOR_INVERT) ? ~c.move_dir : c.move_dir;
                end
            end
            ACT_MOVE_OFS: begin
                if (m_ok) begin
                    s = $signed(m_pos[c.motor]);
                    s = s + $signed(c.offset);
                    d = 1'b1;
                    if (s < 0) begin
                        s = -s;
                        d = 1'b0;
                    end
                    if (s > 65535) begin
                        s = 65535;
                        n_sat++;
                    end
                    m_steps[c.motor] = s[STEP_W-1:0];
                    m_dir[c.motor] = (c.motor == MOTOR_INVERT) ? ~d : d;
                end
            end
            ACT_STOP: begin
                for (int i = 0; i < NUM_MOTORS; i++) m_steps[i] = '0;
            end
            ACT_HOME: begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    m_steps[i] = '0;
                    m_pos[i] = '0;
                end
            end
            ACT_WD_REFRESH: m_wd = c.wd_reload;
            ACT_RAMP_RST:   m_period = cfg_start;
            default: ;
        endcase
        all_zero = 1'b1;
        for (int i = 0; i < NUM_MOTORS; i++) if (m_steps[i] != '0) all_zero = 1'b0;
        r.coils = m_coils;
        r.period = m_period;
        r.all_idle = all_zero;
        r.motor_position = m_ok ? m_pos[c.motor] : '0;
        r.motor_steps_left = m_ok ? m_steps[c.motor] : '0;
        return r;
    endfunction

    function automatic t_cmd mk(logic [2:0] a, logic [MOT_W-1:0] m, logic [STEP_W-1:0] n,
                                logic dr, logic [POS_W-1:0] o, logic h, logic [WD_W-1:0] w);
        t_cmd c;
        c.action = a;
        c.motor = m;
        c.step_count = n;
        c.move_dir = dr;
        c.offset = o;
        c.halt_in = h;
        c.wd_reload = w;
        return c;
    endfunction

    // Mostly well-formed traffic: frequent ticks, regular watchdog refresh, short moves
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   w;
        w = $urandom_range(0, 99);
        if (w < 48)      c.action = ACT_TICK;
        else if (w < 62) c.action = ACT_MOVE_STEPS;
        else if (w < 72) c.action = ACT_MOVE_OFS;
        else if (w < 75) c.action = ACT_STOP;
        else if (w < 77) c.action = ACT_HOME;
        else if (w < 89) c.action = ACT_WD_REFRESH;
        else if (w < 97) c.action = ACT_RAMP_RST;
        else             c.action = ACT_UNUSED;
        c.motor = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        w = $urandom_range(0, 19);
        if (w < 14)      c.step_count = 16'($urandom_range(1, 24));
        else if (w < 16) c.step_count = '0;
        else             c.step_count = 16'($urandom);
        c.move_dir = 1'($urandom);
        c.offset = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60) - 30);
        c.halt_in = ($urandom_range(0, 9) == 0);
        c.wd_reload = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(100, 255)) : 8'($urandom);
        return c;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (n_errors < MAX_PRINTS)
            $display("mismatch on result %0d: %s got %0h, want %0h", rcv_count, what, got, want);
        n_errors++;
    endtask

    task automatic push_cmd(t_cmd c);
        pending.push_back(c);
        queued_cnt++;
    endtask

    // Block the sender until every expected status has come back
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || status_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PER_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_START_PERIOD: cfg_start = val;
            CFG_MIN_PERIOD:   cfg_min = val;
            CFG_RAMP_DEC:     cfg_dec = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int n);
        @(posedge i_clk);
        push_cmd(mk(ACT_RAMP_RST, 0, 0, 0, 0, 0, 0));
        repeat (n) push_cmd(rand_cmd());
        wait_drained();
    endtask

    // Input driver: next command at the falling edge once the last one transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                cur_cmd = pending.pop_front();
                s_axis_tdata <= {6'b0, cur_cmd.wd_reload, cur_cmd.halt_in, cur_cmd.offset,
                                 cur_cmd.move_dir, cur_cmd.step_count};
                s_axis_tuser <= {cur_cmd.motor, cur_cmd.action};
                s_axis_tvalid <= 1'b1;
                gap_left = no_idle ? 0 : gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && rcv_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = no_idle ? 0 : gap_len();
        end
    end

    // Monitor: check each result transfer, then log the input transfer
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rcv_count++;
            got.coils = m_axis_tdata[23:0];
            got.period = m_axis_tdata[39:24];
            got.all_idle = m_axis_tdata[40];
            got.motor_position = m_axis_tdata[56:41];
            got.motor_steps_left = m_axis_tdata[72:57];
            got.watchdog_expired = m_axis_tdata[73];
            if (status_q.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
            end else begin
                want = status_q.pop_front();
                if (got.coils !== want.coils)
                    report_mismatch("coils", 32'(got.coils), 32'(want.coils));
                if (got.period !== want.period)
                    report_mismatch("period", 32'(got.period), 32'(want.period));
                if (got.all_idle !== want.all_idle)
                    report_mismatch("all_idle", 32'(got.all_idle), 32'(want.all_idle));
                if (got.motor_position !== want.motor_position)
                    report_mismatch("motor_position", 32'(unsigned'(got.motor_position)),
                                    32'(unsigned'(want.motor_position)));
                if (got.motor_steps_left !== want.motor_steps_left)
                    report_mismatch("motor_steps_left", 32'(got.motor_steps_left),
                                    32'(want.motor_steps_left));
                if (got.watchdog_expired !== want.watchdog_expired)
                    report_mismatch("watchdog_expired", 32'(got.watchdog_expired),
                                    32'(want.watchdog_expired));
            end
        end
        in_took = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_took) begin
            status_q.push_back(seq_update(cur_cmd));
            accepted_cnt++;
        end
    end

    // Watchdog on stuck handshakes
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
        else quiet++;
        if (quiet >= LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d statuses outstanding",
                     LIMIT, status_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // state after reset
        for (int i = 0; i < NUM_MOTORS; i++) begin
            m_steps[i] = '0;
            m_pos[i] = '0;
            m_phase[i] = '0;
            m_dir[i] = 1'b0;
        end
        m_period = START_PERIOD_RST;
        m_wd = '0;
        m_coils = '0;
        cfg_start = START_PERIOD_RST;
        cfg_min = MIN_PERIOD_RST;
        cfg_dec = RAMP_DEC_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every action, the special cases
        push_cmd(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));                 // watchdog zero from reset
        push_cmd(mk(ACT_WD_REFRESH, 0, 0, 0, 0, 0, 8'hFF));
        push_cmd(mk(ACT_MOVE_STEPS, 0, 16'hFFFF, 1, 0, 0, 0));
        push_cmd(mk(ACT_MOVE_STEPS, 1, 16'h0000, 0, 0, 0, 0));
        push_cmd(mk(ACT_MOVE_STEPS, MOTOR_INVERT, 16'd3, 1, 0, 0, 0));
        push_cmd(mk(ACT_MOVE_STEPS, MOTOR_DRIVER, 16'd2, 1, 0, 0, 0));
        push_cmd(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
        push_cmd(mk(ACT_TICK, 1, 0, 0, 0, 1, 0));                 // halt blanks the coils
        push_cmd(mk(ACT_TICK, MOTOR_COUPLED, 0, 0, 0, 0, 0));
        push_cmd(mk(ACT_MOVE_OFS, 4, 0, 0, 16'h7FFF, 0, 0));
        push_cmd(mk(ACT_MOVE_OFS, 0, 0, 0, 16'h8000, 0, 0));
        push_cmd(mk(ACT_MOVE_STEPS, 3'd6, 16'd5, 1, 0, 0, 0));    // motor out of range
        push_cmd(mk(ACT_MOVE_OFS, 3'd7, 0, 0, 16'd100, 0, 0));
        push_cmd(mk(ACT_UNUSED, 0, 16'hFFFF, 1, 16'hFFFF, 1, 8'hFF));
        push_cmd(mk(ACT_TICK, MOTOR_INVERT, 0, 0, 0, 0, 0));
        push_cmd(mk(ACT_STOP, 0, 0, 0, 0, 0, 0));
        push_cmd(mk(ACT_HOME, 4, 0, 0, 0, 0, 0));
        push_cmd(mk(ACT_RAMP_RST, 0, 0, 0, 0, 0, 0));
        push_cmd(mk(ACT_MOVE_STEPS, MOTOR_COUPLED, 16'd4, 0, 0, 0, 0));
        push_cmd(mk(ACT_WD_REFRESH, 0, 0, 0, 0, 0, 8'h00));
        push_cmd(mk(ACT_TICK, MOTOR_COUPLED, 0, 0, 0, 0, 0));     // refresh with zero expires
        push_cmd(mk(ACT_WD_REFRESH, 0, 0, 0, 0, 0, 8'd2));
        push_cmd(mk(ACT_MOVE_OFS, MOTOR_INVERT, 0, 0, 16'hFFFB, 0, 0));
        repeat (3) push_cmd(mk(ACT_TICK, MOTOR_INVERT, 0, 0, 0, 0, 0));
        wait_drained();

        // Ramp extremes: full drop in one tick
        write_reg(CFG_START_PERIOD, 16'hFFFF);
        write_reg(CFG_MIN_PERIOD, 16'h0000);
        write_reg(CFG_RAMP_DEC, 16'hFFFF);
        run_random(300);

        // Ramp never moves; long output hold-off falls in here
        write_reg(CFG_START_PERIOD, 16'd1);
        write_reg(CFG_MIN_PERIOD, 16'hFFFF);
        write_reg(CFG_RAMP_DEC, 16'h0000);
        run_random(300);

        // Back-to-back traffic, no idling on either side
        no_idle = 1'b1;
        write_reg(CFG_START_PERIOD, 16'd20000);
        write_reg(CFG_MIN_PERIOD, 16'd5000);
        write_reg(CFG_RAMP_DEC, 16'd37);
        write_reg(CFG_UNUSED, 16'($urandom));
        run_random(300);

        no_idle = 1'b0;
        write_reg(CFG_START_PERIOD, 16'($urandom_range(1, 65535)));
        write_reg(CFG_MIN_PERIOD, 16'($urandom_range(0, 65535)));
        write_reg(CFG_RAMP_DEC, 16'($urandom_range(0, 400)));
        run_random(300);
        repeat (8) @(posedge i_clk);

        if (status_q.size() != 0) report_mismatch("missing results", status_q.size(), 0);
        $display("run: %0d commands, %0d ticks (%0d halted, %0d watchdog expiries), %0d results",
                 accepted_cnt, n_ticks, n_halted, n_expired, rcv_count);
        $display("run: %0d motor-5 drags, %0d offset saturations, %0d bad motor ids, %0d errors",
                 n_coupled, n_sat, n_bad_motor, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
